### hdl/ple_pkg.sv
// Shared types and constants of the positional list engine.
package ple_pkg;

	localparam int unsigned KIND_W     = 3;
	localparam int unsigned ELEM_W     = 32;
	localparam int unsigned POS_W      = 8;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned ELEM_CNT_W = 7;

	// Command queue between the front and back ends
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// Request kind codes as they arrive on the command channel
	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd6;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BADPOS = 2'd1,
		STATUS_EMPTY  = 2'd2,
		STATUS_FULL   = 2'd3
	} status_e;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_INS_AT,
		OP_DEL_FRONT,
		OP_DEL_BACK,
		OP_DEL_AT,
		OP_DUMP,
		OP_NOP
	} op_e;

	typedef struct packed {
		op_e                      op;
		logic signed [ELEM_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHUP_RD,
		ST_SHUP_WR,
		ST_PUT,
		ST_SHDN_RD,
		ST_SHDN_WR,
		ST_DMP_RD,
		ST_DMP_OUT,
		ST_RES
	} state_e;

endpackage

### hdl/ple_ifs.sv
// Command and result channel interfaces of the positional list engine.
interface ple_cmd_if import ple_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [ELEM_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [ELEM_W-1:0] element;
	logic [ELEM_CNT_W-1:0]    element_count;
	logic                     last;

	modport source (output valid, status, element, element_count, last, input ready);
	modport sink (input valid, status, element, element_count, last, output ready);
endinterface

### hdl/positional_list_engine.sv
// Positional list engine: a packed, bounded list of signed 32-bit values
// with inserts and deletes at front, back or a 1-based position, and a
// front-to-back dump. A front end decodes and stages one request, which
// passes through a two-entry queue to a back end that owns the element store
// of LIST_DEPTH entries, so new requests are taken while a result waits.
// The back end touches the store once a cycle, a read or a write, so every
// entry moved takes a read state and a write state. An insert moves the
// entries from its slot onward up one and then writes the new value, a
// delete moves the entries after its slot down one, and a dump reads and
// sends each element in turn. The front end registers each request before
// it enters the queue, and a result that is not taken holds the back end in
// place. Errors (full, empty, invalid position) leave the list unchanged.
// No clearing pass follows reset: the store is only read below the element
// count.
module positional_list_engine import ple_pkg::*; #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_cmd_if.sink   cmd,
	ple_rsp_if.source rsp
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t pop_cmd;
	logic q_valid;

	ple_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ple_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (q_valid)
	);

	ple_back #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (pop_cmd),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

### hdl/ple_front.sv
// Front end: accept requests, decode the kind and stage them for the queue.
module ple_front import ple_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ple_cmd_if.sink     cmd,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic v_s1;
	cmd_t cmd_s1;
	op_e  op_dec;
	logic take;

	// Decode the raw kind into an operation
	always_comb begin
		unique case (cmd.kind)
			KIND_INS_FRONT: op_dec = OP_INS_FRONT;
			KIND_INS_BACK:  op_dec = OP_INS_BACK;
			KIND_INS_AT:    op_dec = OP_INS_AT;
			KIND_DEL_FRONT: op_dec = OP_DEL_FRONT;
			KIND_DEL_BACK:  op_dec = OP_DEL_BACK;
			KIND_DEL_AT:    op_dec = OP_DEL_AT;
			KIND_DUMP:      op_dec = OP_DUMP;
			default:        op_dec = OP_NOP;
		endcase
	end

	assign cmd.ready = !v_s1 || !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign push      = v_s1 && !q_full;
	assign push_cmd  = cmd_s1;

	// Hold the staged request until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= '{op: op_dec, value: cmd.value, position: cmd.position};
		end
	end

endmodule

### hdl/ple_queue.sv
// Short command queue between the front and back ends.
module ple_queue import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign full      = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= QPTR_W'((QPTR_W+1)'(wr_ptr_q) + 1'b1 == (QPTR_W+1)'(QUEUE_DEPTH)
					? 0 : wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= QPTR_W'((QPTR_W+1)'(rd_ptr_q) + 1'b1 == (QPTR_W+1)'(QUEUE_DEPTH)
					? 0 : rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### hdl/ple_back.sv
// Back end: run list operations on the element store and drive results.
module ple_back import ple_pkg::*; #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  cmd_t     q_cmd,
	output logic     pop,
	ple_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

	state_e state_q, state_d;

	cmd_t              cmd_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     tgt_q;
	status_e           status_q;

	logic [ELEM_W-1:0] mem_q [LIST_DEPTH];
	logic [ELEM_W-1:0] rd_data_q;

	logic              out_v_q;
	status_e           out_status_q;
	logic [ELEM_W-1:0] out_elem_q;
	logic [CW-1:0]     out_count_q;
	logic              out_last_q;

	// Request decode against the current count
	logic              full;
	logic              empty;
	logic [POS_W:0]    pos_ext;
	logic [POS_W:0]    cnt_ext;
	logic              pos_ok_ins;
	logic              pos_ok_del;
	logic [AW-1:0]     pos_idx;
	logic [AW-1:0]     tgt_d;
	status_e           status_d;
	logic              bad;

	// Control from the output block
	logic              out_free;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ELEM_W-1:0] wr_data;
	logic              load_res;
	logic              load_dump;
	logic              dump_last;
	logic              shdn_more;

	assign out_free  = !out_v_q || rsp.ready;
	assign full      = count_q == CW'(LIST_DEPTH);
	assign empty     = count_q == '0;
	assign pos_ext   = (POS_W+1)'(cmd_q.position);
	assign cnt_ext   = (POS_W+1)'(count_q);
	assign pos_ok_ins = cmd_q.position != '0 && pos_ext <= cnt_ext + 1'b1;
	assign pos_ok_del = cmd_q.position != '0 && pos_ext <= cnt_ext;
	assign pos_idx   = AW'(cmd_q.position - 1'b1);
	assign shdn_more = CW'(idx_q) + 1'b1 < count_q;
	assign dump_last = CW'(idx_q) + 1'b1 == count_q;

	// Classify the outcome of the request held in the back end
	always_comb begin
		tgt_d    = '0;
		status_d = STATUS_OK;
		bad      = 1'b0;
		unique case (cmd_q.op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (full) begin
					status_d = STATUS_FULL;
					bad      = 1'b1;
				end else if (cmd_q.op == OP_INS_AT && !pos_ok_ins) begin
					status_d = STATUS_BADPOS;
					bad      = 1'b1;
				end
				if (cmd_q.op == OP_INS_BACK) begin
					tgt_d = AW'(count_q);
				end else if (cmd_q.op == OP_INS_AT) begin
					tgt_d = pos_idx;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
					bad      = 1'b1;
				end
				if (cmd_q.op == OP_DEL_BACK) begin
					tgt_d = AW'(count_q - 1'b1);
				end
			end
			OP_DEL_AT: begin
				if (!pos_ok_del) begin
					status_d = STATUS_BADPOS;
					bad      = 1'b1;
				end
				tgt_d = pos_idx;
			end
			OP_DUMP: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
					bad      = 1'b1;
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (bad) begin
					state_d = ST_RES;
				end else begin
					unique case (cmd_q.op)
						OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
							state_d = (AW'(count_q) == tgt_d) ? ST_PUT : ST_SHUP_RD;
						OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
							state_d = ST_SHDN_RD;
						default:
							state_d = ST_DMP_RD;
					endcase
				end
			end
			ST_SHUP_RD: state_d = ST_SHUP_WR;
			ST_SHUP_WR: state_d = (idx_q - 1'b1 == tgt_q) ? ST_PUT : ST_SHUP_RD;
			ST_PUT:     state_d = ST_RES;
			ST_SHDN_RD: state_d = shdn_more ? ST_SHDN_WR : ST_RES;
			ST_SHDN_WR: state_d = ST_SHDN_RD;
			ST_DMP_RD:  state_d = ST_DMP_OUT;
			ST_DMP_OUT: begin
				if (out_free) state_d = dump_last ? ST_IDLE : ST_DMP_RD;
			end
			ST_RES: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Store ports and result loads per state
	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = rd_data_q;
		load_res  = 1'b0;
		load_dump = 1'b0;
		unique case (state_q)
			ST_IDLE:    pop = q_valid;
			ST_SHUP_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q - 1'b1;
			end
			ST_SHUP_WR: wr_en = 1'b1;
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = tgt_q;
				wr_data = cmd_q.value;
			end
			ST_SHDN_RD: begin
				rd_en   = shdn_more;
				rd_addr = idx_q + 1'b1;
			end
			ST_SHDN_WR: wr_en = 1'b1;
			ST_DMP_RD:  rd_en = 1'b1;
			ST_DMP_OUT: load_dump = out_free;
			ST_RES:     load_res = out_free;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUT) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_SHDN_RD && !shdn_more) begin
				count_q <= count_q - 1'b1;
			end
			if (load_res || load_dump) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Request fields and walk index
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		unique case (state_q)
			ST_EXEC: begin
				status_q <= status_d;
				tgt_q    <= tgt_d;
				if (cmd_q.op == OP_INS_FRONT || cmd_q.op == OP_INS_BACK ||
				    cmd_q.op == OP_INS_AT) begin
					idx_q <= AW'(count_q);
				end else if (cmd_q.op == OP_DUMP) begin
					idx_q <= '0;
				end else begin
					idx_q <= tgt_d;
				end
			end
			ST_SHUP_WR: idx_q <= idx_q - 1'b1;
			ST_SHDN_WR: idx_q <= idx_q + 1'b1;
			ST_DMP_OUT: begin
				if (out_free && !dump_last) idx_q <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Element store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_res) begin
			out_status_q <= status_q;
			out_elem_q   <= '0;
			out_count_q  <= count_q;
			out_last_q   <= 1'b1;
		end else if (load_dump) begin
			out_status_q <= STATUS_OK;
			out_elem_q   <= rd_data_q;
			out_count_q  <= count_q;
			out_last_q   <= dump_last;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_status_q;
	assign rsp.element       = out_elem_q;
	assign rsp.element_count = ELEM_CNT_W'(out_count_q);
	assign rsp.last          = out_last_q;

endmodule

### hdl/ple_checker.sv
// Port-level checks on the positional list engine, bound to the top level.
module ple_checker import ple_pkg::*; #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [STATUS_W-1:0]      rsp_status,
	input logic signed [ELEM_W-1:0] rsp_element,
	input logic [ELEM_CNT_W-1:0]    rsp_element_count,
	input logic                     rsp_last
);

	// Count never exceeds the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_element_count <= ELEM_CNT_W'(LIST_DEPTH))
		else $error("element count above list depth");

	// A full rejection only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == STATUS_FULL) |->
		rsp_element_count == ELEM_CNT_W'(LIST_DEPTH))
		else $error("full status with list not full");

	// An empty status reports zero elements and ends the request
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == STATUS_EMPTY) |->
		(rsp_element_count == '0 && rsp_last && rsp_element == '0))
		else $error("empty status with elements or not final");

	// Any error ends the request at once with no element
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != STATUS_OK) |-> (rsp_last && rsp_element == '0))
		else $error("error result not final");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_status) && $stable(rsp_element) &&
		 $stable(rsp_element_count) && $stable(rsp_last)))
		else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker #(
	.LIST_DEPTH (LIST_DEPTH)
) u_ple_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_element       (rsp.element),
	.rsp_element_count (rsp.element_count),
	.rsp_last          (rsp.last)
);

### tb/ple_tb_pkg.sv
`timescale 1ns / 100ps
// List shadow and response scoreboard for the positional list engine testbench.
package ple_tb_pkg;
	import ple_pkg::*;

	localparam int unsigned LIST_DEPTH = 16;
	// Kind code with no operation behind it: answers ok and changes nothing
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct {
		status_e                  status;
		logic signed [ELEM_W-1:0] element;
		logic [ELEM_CNT_W-1:0]    count;
		logic                     last;
	} list_rsp_t;

	class list_scoreboard;
		logic signed [ELEM_W-1:0] shadow_list[LIST_DEPTH];
		int unsigned              shadow_len;
		list_rsp_t                pending_rsp[$];
		int unsigned              failures;

		function new();
			shadow_len = 0;
			failures = 0;
		endfunction

		// Queue one response tagged with the element count as it stands now
		function void queue_rsp(status_e status, logic signed [ELEM_W-1:0] element,
				logic last);
			list_rsp_t r;
			r.status = status;
			r.element = element;
			r.count = ELEM_CNT_W'(shadow_len);
			r.last = last;
			pending_rsp.push_back(r);
		endfunction

		// Open a gap at slot idx by moving the tail up one entry
		function void insert_slot(int unsigned idx, logic signed [ELEM_W-1:0] value);
			int unsigned i;
			for (i = shadow_len; i > idx; i--)
				shadow_list[i] = shadow_list[i - 1];
			shadow_list[idx] = value;
			shadow_len++;
		endfunction

		// Close the gap at slot idx by moving the tail down one entry
		function void remove_slot(int unsigned idx);
			int unsigned i;
			for (i = idx; i + 1 < shadow_len; i++)
				shadow_list[i] = shadow_list[i + 1];
			shadow_len--;
		endfunction

		// Apply an accepted request to the shadow list and queue its responses
		function void apply_request(logic [KIND_W-1:0] kind, logic signed [ELEM_W-1:0] value,
				logic [POS_W-1:0] position);
			status_e     st;
			int unsigned i;
			st = STATUS_OK;
			case (kind)
			KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
				// full store wins over a bad position
				if (shadow_len >= LIST_DEPTH)
					st = STATUS_FULL;
				else if (kind == KIND_INS_FRONT)
					insert_slot(0, value);
				else if (kind == KIND_INS_BACK)
					insert_slot(shadow_len, value);
				else if (position < 1 || position > shadow_len + 1)
					st = STATUS_BADPOS;
				else
					insert_slot(position - 1, value);
			end
			KIND_DEL_FRONT, KIND_DEL_BACK: begin
				if (shadow_len == 0)
					st = STATUS_EMPTY;
				else
					remove_slot(kind == KIND_DEL_FRONT ? 0 : shadow_len - 1);
			end
			KIND_DEL_AT: begin
				if (position < 1 || position > shadow_len)
					st = STATUS_BADPOS;
				else
					remove_slot(position - 1);
			end
			KIND_DUMP: begin
				// empty list gives a single empty response
				if (shadow_len == 0) begin
					queue_rsp(STATUS_EMPTY, '0, 1'b1);
					return;
				end
				for (i = 0; i < shadow_len; i++)
					queue_rsp(STATUS_OK, shadow_list[i], i + 1 == shadow_len);
				return;
			end
			default: begin
			end
			endcase
			queue_rsp(st, '0, 1'b1);
		endfunction

		// Compare an accepted response against the oldest outstanding one
		function void check_response(logic [STATUS_W-1:0] status,
				logic signed [ELEM_W-1:0] element, logic [ELEM_CNT_W-1:0] count, logic last);
			list_rsp_t want;
			if (pending_rsp.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: response with no request outstanding: status %0d element %0d count %0d last %0b",
						$time, status, element, count, last);
				return;
			end
			want = pending_rsp.pop_front();
			if (status !== want.status || element !== want.element ||
					count !== want.count || last !== want.last) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: response mismatch: expected status %0d element %0d count %0d last %0b, got status %0d element %0d count %0d last %0b",
						$time, want.status, want.element, want.count, want.last,
						status, element, count, last);
			end
		endfunction
	endclass

endpackage

### tb/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// Testbench top of the positional list engine: directed and random requests, checked responses.
module tb_positional_list_engine;
	import ple_pkg::*;
	import ple_tb_pkg::*;

	logic clk;
	logic arst_n;
	logic stall_rsp = 1'b0;

	int unsigned cmd_idle_pct;
	int unsigned rsp_idle_pct;
	int unsigned requests_taken;

	list_scoreboard list_sb;

	ple_cmd_if cmd_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	// Run the clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one request from a falling edge and hold it until taken
	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic signed [ELEM_W-1:0] value, input logic [POS_W-1:0] position);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.kind     <= kind;
		cmd_ch.value    <= value;
		cmd_ch.position <= position;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		list_sb.apply_request(kind, value, position);
		requests_taken++;
		@(negedge clk);
	endtask

	// Send random requests in stretches that lean toward filling, draining or a mix
	task automatic run_random(input int unsigned total);
		int unsigned              sent;
		int unsigned              n;
		int unsigned              stretch;
		int unsigned              grow_pct;
		int unsigned              pick;
		int unsigned              span;
		logic                     grow;
		logic [KIND_W-1:0]        kind;
		logic signed [ELEM_W-1:0] value;
		logic [POS_W-1:0]         position;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(2))
			0: grow_pct = 85;
			1: grow_pct = 15;
			default: grow_pct = 50;
			endcase
			stretch = $urandom_range(30, 8);
			for (n = 0; n < stretch && sent < total; n++) begin
				// pick the kind
				pick = $urandom_range(99);
				grow = $urandom_range(99) < grow_pct;
				if (pick < 3)
					kind = KIND_UNUSED;
				else if (pick < 13)
					kind = KIND_DUMP;
				else begin
					case ($urandom_range(2))
					0: kind = grow ? KIND_INS_FRONT : KIND_DEL_FRONT;
					1: kind = grow ? KIND_INS_BACK : KIND_DEL_BACK;
					default: kind = grow ? KIND_INS_AT : KIND_DEL_AT;
					endcase
				end
				// pick the position: mostly legal, some at or past the edges
				span = grow ? list_sb.shadow_len + 1 : list_sb.shadow_len;
				pick = $urandom_range(99);
				if (pick < 70)
					position = POS_W'($urandom_range(span > 0 ? span : 1, 1));
				else if (pick < 80)
					position = '0;
				else if (pick < 90)
					position = POS_W'(span + 1);
				else
					position = POS_W'($urandom_range(255));
				// pick the value, extremes now and then
				pick = $urandom_range(99);
				if (pick < 8)
					value = 32'sh7FFFFFFF;
				else if (pick < 16)
					value = 32'sh80000000;
				else if (pick < 20)
					value = '0;
				else if (pick < 24)
					value = -32'sd1;
				else
					value = $urandom;
				send_request(kind, value, position);
				sent++;
			end
		end
	endtask

	// Drive the response ready from falling edges
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= arst_n && !stall_rsp && ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Hold off responses for a long stretch so the engine backs up its input
	initial begin
		wait (requests_taken >= 330);
		stall_rsp = 1'b1;
		repeat (300) @(posedge clk);
		stall_rsp = 1'b0;
	end

	// Check every accepted response
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			list_sb.check_response(rsp_ch.status, rsp_ch.element, rsp_ch.element_count,
				rsp_ch.last);
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Main sequence
	initial begin
		list_sb = new();
		requests_taken = 0;
		cmd_idle_pct = 32;
		rsp_idle_pct = 50;
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_INS_FRONT;
		cmd_ch.value = '0;
		cmd_ch.position = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list corners
		send_request(KIND_DUMP, '0, '0);
		send_request(KIND_DEL_FRONT, '0, '0);
		send_request(KIND_DEL_BACK, '0, '0);
		send_request(KIND_DEL_AT, '0, 8'd1);
		send_request(KIND_DEL_AT, '0, 8'd0);
		send_request(KIND_INS_AT, 32'sd9, 8'd0);
		send_request(KIND_INS_AT, 32'sd9, 8'd2);
		// one-element list emptied by each delete kind
		send_request(KIND_INS_AT, 32'sd5, 8'd1);
		send_request(KIND_DEL_BACK, '0, '0);
		send_request(KIND_INS_FRONT, 32'sh7FFFFFFF, 8'hFF);
		send_request(KIND_DEL_FRONT, '0, '0);
		send_request(KIND_INS_BACK, 32'sh80000000, '0);
		send_request(KIND_DEL_AT, '0, 8'd1);
		// build a short list and hit the position edges
		send_request(KIND_INS_FRONT, -32'sd1, '0);
		send_request(KIND_INS_BACK, 32'sh12345678, '0);
		send_request(KIND_INS_AT, 32'sh80000000, 8'd2);
		send_request(KIND_INS_AT, 32'sd3, 8'hFF);
		send_request(KIND_INS_AT, 32'sd7, 8'd4);
		send_request(KIND_UNUSED, -32'sd1, 8'hFF);
		send_request(KIND_DUMP, '0, '0);
		send_request(KIND_DEL_AT, '0, 8'd5);
		send_request(KIND_DEL_AT, '0, 8'hFF);
		send_request(KIND_DEL_AT, '0, 8'd2);
		send_request(KIND_DEL_AT, '0, 8'd3);
		send_request(KIND_DUMP, '0, '0);

		run_random(150);
		cmd_idle_pct = 50;
		rsp_idle_pct = 32;
		run_random(150);
		cmd_idle_pct = 0;
		rsp_idle_pct = 0;
		run_random(160);
		cmd_ch.valid <= 1'b0;

		// drain outstanding responses, then watch for strays
		while (list_sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (list_sb.failures == 0 && list_sb.pending_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### positional_list_engine.f
hdl/ple_pkg.sv
hdl/ple_ifs.sv
hdl/ple_front.sv
hdl/ple_queue.sv
hdl/ple_back.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
tb/ple_tb_pkg.sv
tb/tb_positional_list_engine.sv
